// File: src/palu_pkg.sv
// ----------------------------------------------------------------------------
// palu_pkg
// shared types and constants for the positional array list unit
// ----------------------------------------------------------------------------
package palu_pkg;

	// default list geometry
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// width of position, count and capacity fields
	localparam int CNT_W = 7;

	// capacity register value after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	// operation codes carried by the mode field
	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_INSERT = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;     // capture the incoming word
		logic eval;      // capture the accept/refuse decision
		logic ptr_init;  // load the shift pointer
		logic rd_pos;    // read the entry at the requested position
		logic rd_src;    // read the neighbor the shift pulls from
		logic wr_val;    // write the new value at the requested position
		logic wr_shift;  // write the shifted entry at the pointer, step pointer
		logic cnt_inc;
		logic cnt_dec;
	} palu_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		mode_t mode;
		logic  op_ok;       // operation is allowed
		logic  no_shift;    // insert at tail or remove of the last element
		logic  shift_done;  // current shift write is the last one
	} palu_stat_t;

endpackage

// File: src/positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// positional_array_list_unit
// ordered list of signed words with read, overwrite, insert and remove by
// 1-based position
// ----------------------------------------------------------------------------
// a word is taken at the clock edge where start is high and busy is low.
// exactly one result follows per word, shown for one cycle while done is
// high; the receiver cannot stall, so sample the result ports whenever done
// is set. start is ignored while busy. the elements live in a memory with one
// write and one registered read port, so an insert or remove moves its
// elements one at a time, a shift read and then a shift write for each:
// count - position + 1 elements move for an insert and count - position for
// a remove. capacity is written through cfg_we/cfg_wdata; the user must write
// it only while the unit is idle, and the unit itself does not enforce this;
// it resets to 64, and the usable capacity is the smaller of it and DEPTH.
// element memory comes up undefined; only entries below the count are read.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
	parameter int DEPTH      = palu_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = palu_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [palu_pkg::CNT_W-1:0]   position,
	input  logic signed [DATA_WIDTH-1:0] value_in,
	// capacity register
	input  logic                         cfg_we,
	input  logic [palu_pkg::CNT_W-1:0]   cfg_wdata,
	// result side
	output logic                         done,
	output logic                         ok,
	output logic signed [DATA_WIDTH-1:0] value_out,
	output logic [palu_pkg::CNT_W-1:0]   element_count,
	output logic                         is_empty,
	output logic                         is_full
);

	palu_pkg::palu_cmd_t  cmd;
	palu_pkg::palu_stat_t stat;

	// sequencing: check, optional shift loop, final write, result strobe
	palu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// storage, count and the per-operation bounds checks
	palu_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (palu_pkg::mode_t'(mode)),
		.position      (position),
		.value_in      (value_in),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.ok            (ok),
		.value_out     (value_out),
		.element_count (element_count),
		.is_empty      (is_empty),
		.is_full       (is_full)
	);

endmodule

// File: src/palu_dp.sv
// ----------------------------------------------------------------------------
// palu_dp
// datapath: element memory, count, capacity, pointer and decision logic
// ----------------------------------------------------------------------------
module palu_dp #(
	parameter int DEPTH      = palu_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = palu_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  palu_pkg::palu_cmd_t            cmd,
	output palu_pkg::palu_stat_t           stat,
	input  palu_pkg::mode_t                mode,
	input  logic [palu_pkg::CNT_W-1:0]     position,
	input  logic signed [DATA_WIDTH-1:0]   value_in,
	input  logic                           cfg_we,
	input  logic [palu_pkg::CNT_W-1:0]     cfg_wdata,
	output logic                           ok,
	output logic signed [DATA_WIDTH-1:0]   value_out,
	output logic [palu_pkg::CNT_W-1:0]     element_count,
	output logic                           is_empty,
	output logic                           is_full
);

	localparam int CW = palu_pkg::CNT_W;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// compare width: holds count+1, DEPTH and any address
	localparam int W  = ((CW + 1) > (AW + 1)) ? (CW + 1) : (AW + 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	palu_pkg::mode_t       mode_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         cap_q;
	logic [AW-1:0]         ptr_q;
	logic                  ok_q;

	logic [W-1:0]  pos_w, count_w, cap_w, pos_m1_w, ptr_w;
	logic [AW-1:0] pos_m1_a, count_a, raddr, waddr, ptr_next, ptr_src;
	logic          full, pos_nz, in_list, ins_ok, re, we;
	logic [DATA_WIDTH-1:0] wdata;

	assign pos_w    = W'(pos_q);
	assign count_w  = W'(count_q);
	assign cap_w    = W'(cap_q);
	assign ptr_w    = W'(ptr_q);
	assign pos_m1_w = pos_w - W'(1);
	assign pos_m1_a = pos_m1_w[AW-1:0];
	assign count_a  = count_w[AW-1:0];

	// effective capacity is the smaller of the register and the depth
	assign full    = (count_w >= cap_w) || (count_w >= W'(DEPTH));
	assign pos_nz  = (pos_q != '0);
	assign in_list = pos_nz && (pos_w <= count_w);
	assign ins_ok  = !full && pos_nz && (pos_w <= count_w + W'(1));

	always_comb begin
		stat.mode       = mode_q;
		stat.op_ok      = 1'b0;
		stat.no_shift   = 1'b0;
		stat.shift_done = 1'b0;
		ptr_next        = ptr_q;
		ptr_src         = ptr_q;
		case (mode_q)
			palu_pkg::MODE_INSERT: begin
				stat.op_ok      = ins_ok;
				stat.no_shift   = (pos_w == count_w + W'(1));
				stat.shift_done = (ptr_w == pos_w);
				ptr_next        = ptr_q - AW'(1);
				ptr_src         = ptr_q - AW'(1);
			end
			palu_pkg::MODE_REMOVE: begin
				stat.op_ok      = in_list;
				stat.no_shift   = (pos_w == count_w);
				stat.shift_done = (ptr_w + W'(2) == count_w);
				ptr_next        = ptr_q + AW'(1);
				ptr_src         = ptr_q + AW'(1);
			end
			default: begin
				stat.op_ok = in_list;
			end
		endcase
	end

	// memory port selection
	assign re    = cmd.rd_pos || cmd.rd_src;
	assign raddr = cmd.rd_src ? ptr_src : pos_m1_a;
	assign we    = cmd.wr_val || cmd.wr_shift;
	assign waddr = cmd.wr_shift ? ptr_q : pos_m1_a;
	assign wdata = cmd.wr_shift ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// captured word
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pos_q <= position;
			val_q <= value_in;
		end
		if (cmd.ptr_init) begin
			ptr_q <= (mode_q == palu_pkg::MODE_INSERT) ? count_a : pos_m1_a;
		end else if (cmd.wr_shift) begin
			ptr_q <= ptr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= palu_pkg::MODE_READ;
			count_q <= '0;
			cap_q   <= palu_pkg::CAP_RESET;
			ok_q    <= 1'b0;
		end else begin
			if (cmd.latch) begin
				mode_q <= mode;
			end
			if (cmd.eval) begin
				ok_q <= stat.op_ok;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	assign ok            = ok_q;
	assign value_out     = (ok_q && mode_q == palu_pkg::MODE_READ) ? rdata_q : '0;
	assign element_count = count_q;
	assign is_empty      = (count_q == '0);
	assign is_full       = full;

endmodule

// File: src/palu_ctrl.sv
// ----------------------------------------------------------------------------
// palu_ctrl
// controller state machine: sequences checks, shifts and the result strobe
// ----------------------------------------------------------------------------
module palu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  palu_pkg::palu_stat_t stat,
	output palu_pkg::palu_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EVAL   = 6'b000010,
		ST_SH_RD  = 6'b000100,
		ST_SH_WR  = 6'b001000,
		ST_INS_WR = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_RESP;
				if (stat.op_ok) begin
					unique case (stat.mode)
						palu_pkg::MODE_READ:  cmd.rd_pos = 1'b1;
						palu_pkg::MODE_WRITE: cmd.wr_val = 1'b1;
						palu_pkg::MODE_INSERT: begin
							cmd.ptr_init = 1'b1;
							state_d      = stat.no_shift ? ST_INS_WR : ST_SH_RD;
						end
						palu_pkg::MODE_REMOVE: begin
							cmd.ptr_init = 1'b1;
							if (stat.no_shift) begin
								cmd.cnt_dec = 1'b1;
							end else begin
								state_d = ST_SH_RD;
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_SH_RD: begin
				cmd.rd_src = 1'b1;
				state_d    = ST_SH_WR;
			end
			ST_SH_WR: begin
				cmd.wr_shift = 1'b1;
				if (!stat.shift_done) begin
					state_d = ST_SH_RD;
				end else if (stat.mode == palu_pkg::MODE_INSERT) begin
					state_d = ST_INS_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_RESP;
				end
			end
			ST_INS_WR: begin
				cmd.wr_val  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule

// File: src/palu_checker.sv
// ----------------------------------------------------------------------------
// palu_checker
// port-level checks for the positional array list unit
// ----------------------------------------------------------------------------
module palu_checker #(
	parameter int DATA_WIDTH = palu_pkg::DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         ok,
	input logic signed [DATA_WIDTH-1:0] value_out,
	input logic [palu_pkg::CNT_W-1:0]   element_count,
	input logic                         is_empty
);

	// an accepted word keeps the unit busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after accepting a word");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// a result only appears while a word is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while idle");

	// refused operations return a zero value
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> value_out == '0)
		else $error("nonzero value on a refused operation");

	// empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> is_empty == (element_count == '0))
		else $error("empty flag disagrees with count");

endmodule

bind positional_array_list_unit palu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_palu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.ok            (ok),
	.value_out     (value_out),
	.element_count (element_count),
	.is_empty      (is_empty)
);
